@@ sv/efr_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared widths, register indexes, result codes, item types and the CRC step.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam int BYTE_W    = 8;
	localparam int CRC_W     = 16;
	localparam int LEN_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int CRC_BYTES = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESIDUE = 3'd4;

	// Configuration reset values.
	localparam logic [BYTE_W-1:0] FLAG_RST    = 8'h7e;
	localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'h7d;
	localparam logic [BYTE_W-1:0] FLIP_RST    = 8'h20;
	localparam logic [CRC_W-1:0]  PRESET_RST  = 16'hffff;
	localparam logic [CRC_W-1:0]  RESIDUE_RST = 16'hf0b8;

	// Frame status codes.
	localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CRC_BAD = 2'd2;

	// Result item kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   header;
		logic [LEN_W-1:0]    length;
		logic [BYTE_W-1:0]   data;
		logic                last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;       // a line byte transfer happens this cycle
		logic load_status;  // load the pending status item into the output register
		logic rd_req;       // read the next payload byte from the frame store
		logic load_data;    // load the payload byte just read into the output register
	} efr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic closes_frame; // the offered byte is a flag that ends a frame with a header
		logic has_payload;  // the pending status item is a good frame with payload
		logic last_payload; // the payload byte being read is the final one
		logic out_free;     // the output register can take an item this cycle
	} efr_sts_t;

	// One step of the reflected CRC-CCITT (polynomial 0x8408), one byte at a time.
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] t;
		t = b ^ acc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {t, acc[15:8]} ^ {12'b0, t[7:4]} ^ {5'b0, t, 3'b000};
	endfunction

endpackage

@@ sv/efr_if.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver channel interfaces
// Valid/ready channels for line bytes, result items and register writes.
// ----------------------------------------------------------------------------
interface efr_line_if import efr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink (input valid, input line_byte, output ready);
endinterface

interface efr_result_if import efr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   header;
	logic [LEN_W-1:0]    length;
	logic [BYTE_W-1:0]   data;
	logic                last;

	modport source (output valid, output kind, output status, output header,
		output length, output data, output last, input ready);
	modport sink (input valid, input kind, input status, input header,
		input length, input data, input last, output ready);
endinterface

interface efr_cfg_if import efr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/escaped_frame_receiver_crc16_unit.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver with CRC-16 check
// Byte-stuffed deframer that reports frame status and replays good payloads.
// ----------------------------------------------------------------------------
// Throughput: one line byte per cycle while no frame closes; a closing flag
// holds the line channel while the status item and then each payload byte,
// read through the registered frame store, go out (longer on result stalls).
// The status item is loaded when the output register is free after its flag.
// Reset (arst_n low) clears the receiver and loads the register defaults; the
// frame store is not cleared and takes no clearing pass.
module escaped_frame_receiver_crc16_unit import efr_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	efr_line_if.sink      line,
	efr_result_if.source  result,
	efr_cfg_if.sink       cfg
);

	efr_cmd_t  cmd;
	efr_sts_t  sts;
	out_item_t out_item;
	logic      out_valid;
	logic      line_ready;

	// Register writes are always taken; they are meant to arrive only while no
	// frame is in flight.
	assign cfg.ready = 1'b1;

	assign line.ready = line_ready;

	// The result channel is driven straight from the datapath output register,
	// so a finished item waits there while the controller keeps taking bytes.
	assign result.valid  = out_valid;
	assign result.kind   = out_item.kind;
	assign result.status = out_item.status;
	assign result.header = out_item.header;
	assign result.length = out_item.length;
	assign result.data   = out_item.data;
	assign result.last   = out_item.last;

	// The controller decides when a byte transfer happens and walks the
	// status-then-payload sequence that follows a closing flag.
	efr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(line.valid),
		.in_ready(line_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the unescape, CRC and store logic and the result register.
	efr_dp #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid && cfg.ready),
		.cfg_idx  (cfg.index),
		.cfg_wdata(cfg.data),
		.line_byte(line.line_byte),
		.out_ready(result.ready),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_item (out_item)
	);

	// At most one command is issued per cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_status, cmd.rd_req, cmd.load_data}))
		else $error("more than one controller command in a cycle");

	// An item is loaded only when the output register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_status || cmd.load_data) |-> sts.out_free)
		else $error("output register overwritten");

	// A status item with payload is followed by a store read, not by a byte.
	a_drain_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_status && sts.has_payload) |=> (cmd.rd_req && !line.ready))
		else $error("payload drain did not start after good status");

	// No line byte is taken while a store read is in flight.
	a_no_byte_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_req |=> !(line.valid && line.ready))
		else $error("line byte transfer during payload read");

endmodule

@@ sv/efr_ram.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module efr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/efr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver controller
// Sequences byte intake, the status item and the payload drain.
// ----------------------------------------------------------------------------
module efr_ctrl import efr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  efr_sts_t sts,
	output efr_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STATUS,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid && ready_q;
				if (cmd.accept && sts.closes_frame) begin
					state_d = S_STATUS;
				end
			end
			S_STATUS: begin
				if (sts.out_free) begin
					cmd.load_status = 1'b1;
					state_d = sts.has_payload ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd_req = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					state_d = sts.last_payload ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

endmodule

@@ sv/efr_dp.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver datapath
// Unescaping, CRC, frame store, configuration and the output register.
// ----------------------------------------------------------------------------
module efr_dp import efr_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic [BYTE_W-1:0]    line_byte,
	input  logic                 out_ready,
	input  efr_cmd_t             cmd,
	output efr_sts_t             sts,
	output logic                 out_valid,
	output out_item_t            out_item
);

	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

	// Configuration registers.
	logic [BYTE_W-1:0] flag_q;
	logic [BYTE_W-1:0] esc_q;
	logic [BYTE_W-1:0] flip_q;
	logic [CRC_W-1:0]  preset_q;
	logic [CRC_W-1:0]  residue_q;

	// Receiver state.
	logic              escaping_q;
	logic              in_frame_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] header_q;

	// Pending status and drain state.
	logic [STATUS_W-1:0] pend_status_q;
	logic [LEN_W-1:0]    pend_len_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [BYTE_W-1:0]   byte_x;
	logic                is_flag;
	logic                is_esc;
	logic                is_data;
	logic                overflow;
	logic [CRC_W-1:0]    crc_next;
	logic                store_we;
	logic [STATUS_W-1:0] frame_status;
	logic [LEN_W-1:0]    frame_len;
	logic [BYTE_W-1:0]   ram_rdata;

	always_comb begin
		is_flag  = (line_byte == flag_q);
		is_esc   = !is_flag && (line_byte == esc_q);
		is_data  = !is_flag && !is_esc;
		byte_x   = escaping_q ? (line_byte ^ flip_q) : line_byte;
		crc_next = crc_feed(crc_q, byte_x);
		overflow = (count_q >= CNT_W'(MAX_FRAME_BYTES));
		store_we = cmd.accept && is_data && in_frame_q && !overflow;

		frame_len = '0;
		if (count_q < CNT_W'(CRC_BYTES)) begin
			frame_status = ST_SHORT;
		end else if (crc_q != residue_q) begin
			frame_status = ST_CRC_BAD;
		end else begin
			frame_status = ST_GOOD;
			frame_len    = LEN_W'(count_q - CNT_W'(CRC_BYTES));
		end
	end

	assign sts.closes_frame = is_flag && in_frame_q;
	assign sts.has_payload  = (pend_status_q == ST_GOOD) && (pend_len_q != '0);
	assign sts.last_payload = (LEN_W'(rd_idx_q) == (pend_len_q - LEN_W'(1)));
	assign sts.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= FLAG_RST;
			esc_q     <= ESCAPE_RST;
			flip_q    <= FLIP_RST;
			preset_q  <= PRESET_RST;
			residue_q <= RESIDUE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FLAG:    flag_q    <= cfg_wdata[BYTE_W-1:0];
				CFG_ESCAPE:  esc_q     <= cfg_wdata[BYTE_W-1:0];
				CFG_FLIP:    flip_q    <= cfg_wdata[BYTE_W-1:0];
				CFG_PRESET:  preset_q  <= cfg_wdata;
				CFG_RESIDUE: residue_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escaping_q  <= 1'b0;
			in_frame_q  <= 1'b0;
			crc_q       <= PRESET_RST;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (is_flag) begin
					escaping_q <= 1'b0;
					in_frame_q <= 1'b0;
					crc_q      <= preset_q;
					count_q    <= '0;
				end else if (is_esc) begin
					escaping_q <= 1'b1;
				end else begin
					escaping_q <= 1'b0;
					if (!in_frame_q) begin
						in_frame_q <= 1'b1;
						crc_q      <= crc_next;
					end else if (overflow) begin
						// Too long: drop the frame and wait for a new header.
						in_frame_q <= 1'b0;
						crc_q      <= preset_q;
						count_q    <= '0;
					end else begin
						crc_q   <= crc_next;
						count_q <= count_q + CNT_W'(1);
					end
				end
			end

			if (cmd.load_status) begin
				rd_idx_q <= '0;
			end else if (cmd.load_data) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end

			if (cmd.load_status || cmd.load_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_data && !in_frame_q) begin
			header_q <= byte_x;
		end
		if (cmd.accept && sts.closes_frame) begin
			pend_status_q <= frame_status;
			pend_len_q    <= frame_len;
		end
		if (cmd.load_status) begin
			out_item_q.kind   <= KIND_STATUS;
			out_item_q.status <= pend_status_q;
			out_item_q.header <= header_q;
			out_item_q.length <= pend_len_q;
			out_item_q.data   <= '0;
			out_item_q.last   <= !sts.has_payload;
		end else if (cmd.load_data) begin
			out_item_q.kind   <= KIND_DATA;
			out_item_q.status <= ST_GOOD;
			out_item_q.header <= '0;
			out_item_q.length <= '0;
			out_item_q.data   <= ram_rdata;
			out_item_q.last   <= sts.last_payload;
		end
	end

	efr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_FRAME_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (store_we),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(byte_x),
		.rd_en  (cmd.rd_req),
		.rd_addr(rd_idx_q),
		.rd_data(ram_rdata)
	);

endmodule
